### design/hlfb_pkg.sv
// ----------------------------------------------------------------------------
// hlfb_pkg
// Shared constants, types and the CRC-16 byte update for the frame builder.
// ----------------------------------------------------------------------------
package hlfb_pkg;

   localparam logic [15:0] CRC_POLY   = 16'h1021;
   localparam logic [15:0] CRC_INIT   = 16'hFFFF;
   localparam logic [7:0]  FLAG_BYTE  = 8'h7E;
   localparam logic [7:0]  ADDR_BYTE  = 8'hFF;
   localparam logic [7:0]  CTRL_BYTE  = 8'h03;
   localparam logic [7:0]  PID_HI_BYTE = 8'hC0;
   localparam logic [7:0]  PID_LO_BYTE = 8'h21;

   // Byte slots of one outgoing frame, in emission order
   typedef enum logic [3:0] {
      STEP_FLAG_OPEN = 4'd0,
      STEP_ADDR      = 4'd1,
      STEP_CTRL      = 4'd2,
      STEP_PID_HI    = 4'd3,
      STEP_PID_LO    = 4'd4,
      STEP_CODE      = 4'd5,
      STEP_DATA      = 4'd6,
      STEP_CRC_HI    = 4'd7,
      STEP_CRC_LO    = 4'd8,
      STEP_FLAG_END  = 4'd9
   } step_type;

   // Control from the sequencer to the check accumulator
   typedef struct packed {
      logic       init;    // restart at CRC_INIT
      logic       update;  // fold data into the running value
      logic [7:0] data;
   } crc_ctl_type;

   // CRC-16, MSB first, one byte
   function automatic logic [15:0] crc16_byte(input logic [15:0] crc,
                                              input logic [7:0]  b);
      logic [15:0] c;
      c = crc ^ {b, 8'h00};
      for (int i = 0; i < 8; i++) begin
         if (c[15]) begin
            c = {c[14:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[14:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

### design/hlfb_crc_acc.sv
// ----------------------------------------------------------------------------
// hlfb_crc_acc
// Running CRC-16 check value, one byte folded in per cycle while update is set.
// ----------------------------------------------------------------------------
module hlfb_crc_acc
   import hlfb_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  crc_ctl_type ctl,
   output logic [15:0] crc_value
);

   logic [15:0] crc_ff;
   logic [15:0] crc_in;

   always_comb begin
      crc_in = crc_ff;
      if (ctl.init) begin
         crc_in = CRC_INIT;
      end else if (ctl.update) begin
         crc_in = crc16_byte(crc_ff, ctl.data);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff <= CRC_INIT;
      end else begin
         crc_ff <= crc_in;
      end
   end

   assign crc_value = crc_ff;

endmodule

### design/hdlc_like_frame_builder_crc16.sv
// ----------------------------------------------------------------------------
// hdlc_like_frame_builder_crc16
// Frame builder: header, payload, CRC-16 trailer and closing flag.
// ----------------------------------------------------------------------------
// An accepted item is held, then its bytes pass through the output register.
// Throughput: one output byte per cycle while rsp_tready allows. A payload item
// in an open frame sends its data byte; a frame's first item adds the header,
// the last the CRC and closing flag. Open frame, no data, no last mark: nothing.
// Reset: synchronous, clears the frame state, the holding and output stages.
module hdlc_like_frame_builder_crc16
   import hlfb_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [7:0] frame_code, [15:8] data_byte
   input  logic        req_tuser,   // [0] has_data
   input  logic        req_tlast,   // last_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [7:0] frame_byte
   output logic        rsp_tuser,   // [0] frame_end
   output logic        rsp_tlast    // run_last
);

   // frame state as seen by accepted transfers
   logic        open_ff, open_in;
   // holding stage for the item being emitted
   logic        hold_valid_ff, hold_valid_in;
   logic [7:0]  code_ff, code_in;
   logic [7:0]  data_ff, data_in;
   logic        has_data_ff, has_data_in;
   logic        last_ff, last_in;
   step_type    step_ff, step_in;
   // output register
   logic        out_valid_ff, out_valid_in;
   logic [7:0]  out_byte_ff, out_byte_in;
   logic        out_last_ff, out_last_in;
   logic        out_end_ff, out_end_in;

   logic        accept;
   logic        no_output;
   logic        out_load;
   logic        final_step;
   step_type    next_step;
   step_type    first_step;
   logic [7:0]  cur_byte;
   logic [15:0] crc_value;
   crc_ctl_type crc_ctl;

   hlfb_crc_acc u_crc (
      .clock     (clock),
      .reset     (reset),
      .ctl       (crc_ctl),
      .crc_value (crc_value)
   );

   assign out_load  = hold_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !hold_valid_ff || (out_load && final_step);
   assign accept    = req_tvalid && req_tready;
   // open frame, no data, not closing: nothing to send
   assign no_output = open_ff && !req_tuser && !req_tlast;

   always_comb begin
      if (!open_ff) begin
         first_step = STEP_FLAG_OPEN;
      end else if (req_tuser) begin
         first_step = STEP_DATA;
      end else begin
         first_step = STEP_CRC_HI;
      end
   end

   // byte and successor of the current slot
   always_comb begin
      cur_byte   = FLAG_BYTE;
      next_step  = STEP_FLAG_END;
      final_step = 1'b0;
      case (step_ff)
         STEP_FLAG_OPEN: begin
            cur_byte  = FLAG_BYTE;
            next_step = STEP_ADDR;
         end
         STEP_ADDR: begin
            cur_byte  = ADDR_BYTE;
            next_step = STEP_CTRL;
         end
         STEP_CTRL: begin
            cur_byte  = CTRL_BYTE;
            next_step = STEP_PID_HI;
         end
         STEP_PID_HI: begin
            cur_byte  = PID_HI_BYTE;
            next_step = STEP_PID_LO;
         end
         STEP_PID_LO: begin
            cur_byte  = PID_LO_BYTE;
            next_step = STEP_CODE;
         end
         STEP_CODE: begin
            cur_byte   = code_ff;
            next_step  = has_data_ff ? STEP_DATA : STEP_CRC_HI;
            final_step = !has_data_ff && !last_ff;
         end
         STEP_DATA: begin
            cur_byte   = data_ff;
            next_step  = STEP_CRC_HI;
            final_step = !last_ff;
         end
         STEP_CRC_HI: begin
            cur_byte  = crc_value[15:8];
            next_step = STEP_CRC_LO;
         end
         STEP_CRC_LO: begin
            cur_byte  = crc_value[7:0];
            next_step = STEP_FLAG_END;
         end
         STEP_FLAG_END: begin
            cur_byte   = FLAG_BYTE;
            final_step = 1'b1;
         end
         default: begin
            cur_byte   = FLAG_BYTE;
            final_step = 1'b1;
         end
      endcase
   end

   always_comb begin
      crc_ctl.init   = out_load && (step_ff == STEP_FLAG_OPEN || step_ff == STEP_FLAG_END);
      crc_ctl.update = out_load && (step_ff == STEP_ADDR || step_ff == STEP_CTRL ||
                                    step_ff == STEP_PID_HI || step_ff == STEP_PID_LO ||
                                    step_ff == STEP_CODE || step_ff == STEP_DATA);
      crc_ctl.data   = cur_byte;
   end

   always_comb begin
      open_in       = open_ff;
      hold_valid_in = hold_valid_ff;
      code_in       = code_ff;
      data_in       = data_ff;
      has_data_in   = has_data_ff;
      last_in       = last_ff;
      step_in       = step_ff;

      if (out_load) begin
         step_in = next_step;
         if (final_step) begin
            hold_valid_in = 1'b0;
         end
      end

      if (accept) begin
         open_in = !req_tlast;
         if (!no_output) begin
            hold_valid_in = 1'b1;
            code_in       = req_tdata[7:0];
            data_in       = req_tdata[15:8];
            has_data_in   = req_tuser;
            last_in       = req_tlast;
            step_in       = first_step;
         end
      end

      out_valid_in = out_valid_ff;
      out_byte_in  = out_byte_ff;
      out_last_in  = out_last_ff;
      out_end_in   = out_end_ff;
      if (out_load) begin
         out_valid_in = 1'b1;
         out_byte_in  = cur_byte;
         out_last_in  = final_step;
         out_end_in   = (step_ff == STEP_FLAG_END);
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         open_ff       <= 1'b0;
         hold_valid_ff <= 1'b0;
         step_ff       <= STEP_FLAG_OPEN;
         out_valid_ff  <= 1'b0;
      end else begin
         open_ff       <= open_in;
         hold_valid_ff <= hold_valid_in;
         step_ff       <= step_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      code_ff     <= code_in;
      data_ff     <= data_in;
      has_data_ff <= has_data_in;
      last_ff     <= last_in;
      out_byte_ff <= out_byte_in;
      out_last_ff <= out_last_in;
      out_end_ff  <= out_end_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_byte_ff;
   assign rsp_tlast  = out_last_ff;
   assign rsp_tuser  = out_end_ff;

endmodule
